@@ design/mdbp_pkg.sv @@
package mdbp_pkg;

    localparam int MAX_AREAS   = 16;
    localparam int COORD_BITS  = 12;
    localparam int AREA_IDX_W  = $clog2(MAX_AREAS);
    localparam int COUNT_W     = $clog2(MAX_AREAS + 1);
    localparam int SLOT_W      = 5;
    localparam int POS_W       = COORD_BITS + 8;

    localparam int IN_DATA_W   = 120;
    localparam int OUT_DATA_W  = 88;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] MODE_PIXEL = 2'd0;
    localparam logic [1:0] MODE_RECT  = 2'd1;
    localparam logic [1:0] MODE_COUNT = 2'd2;

    localparam logic [2:0] CFG_CENTER_X    = 3'd0;
    localparam logic [2:0] CFG_CENTER_Y    = 3'd1;
    localparam logic [2:0] CFG_INV_FOCAL_X = 3'd2;
    localparam logic [2:0] CFG_INV_FOCAL_Y = 3'd3;
    localparam logic [2:0] CFG_DEPTH_MIN   = 3'd4;
    localparam logic [2:0] CFG_DEPTH_MAX   = 3'd5;
    localparam logic [2:0] CFG_MASK_MARGIN = 3'd6;

    typedef struct packed {
        logic [19:0] center_x;
        logic [19:0] center_y;
        logic [23:0] inv_focal_x;
        logic [23:0] inv_focal_y;
        logic [15:0] depth_min;
        logic [15:0] depth_max;
        logic [7:0]  mask_margin;
    } cfg_t;

    typedef struct packed {
        logic [7:0]            red;
        logic [7:0]            green;
        logic [7:0]            blue;
        logic [15:0]           depth;
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
    } pixel_t;

endpackage

@@ design/mdbp_front.sv @@
module mdbp_front
    import mdbp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [IN_DATA_W-1:0] in_data,
    input  logic [1:0]           in_mode,
    input  logic                 full,
    output logic                 push,
    output pixel_t               push_data
);

    logic [COORD_BITS-1:0] area_left_reg   [MAX_AREAS];
    logic [COORD_BITS-1:0] area_top_reg    [MAX_AREAS];
    logic [COORD_BITS-1:0] area_right_reg  [MAX_AREAS];
    logic [COORD_BITS-1:0] area_bottom_reg [MAX_AREAS];
    logic [COUNT_W-1:0]    area_count_reg;
    logic [COUNT_W-1:0]    area_count_next;

    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic [15:0]           depth;
    logic [SLOT_W-1:0]     slot;
    logic [COORD_BITS-1:0] rect_left;
    logic [COORD_BITS-1:0] rect_top;
    logic [COORD_BITS-1:0] rect_right;
    logic [COORD_BITS-1:0] rect_bottom;
    logic [COORD_BITS:0]   margin_ext;
    logic [COORD_BITS:0]   col_ext;
    logic [COORD_BITS:0]   row_ext;
    logic [COORD_BITS:0]   col_grown;
    logic [COORD_BITS:0]   row_grown;
    logic                  accept;
    logic                  hit;
    logic                  depth_ok;

    assign col         = in_data[11:0];
    assign row         = in_data[23:12];
    assign depth       = in_data[39:24];
    assign slot        = in_data[68:64];
    assign rect_left   = in_data[80:69];
    assign rect_top    = in_data[92:81];
    assign rect_right  = in_data[104:93];
    assign rect_bottom = in_data[116:105];

    assign in_ready = !full;
    assign accept   = in_valid && !full;

    assign margin_ext = {{(COORD_BITS - 7){1'b0}}, cfg.mask_margin};
    assign col_ext    = {1'b0, col};
    assign row_ext    = {1'b0, row};
    assign col_grown  = col_ext + margin_ext;
    assign row_grown  = row_ext + margin_ext;

    // c > left - m  <=>  c + m > left, no wrap at this width
    always_comb
    begin
        hit = 1'b0;
        for (int i = 0; i < MAX_AREAS; i++)
        begin
            if ((COUNT_W'(i) < area_count_reg) &&
                (col_grown > {1'b0, area_left_reg[i]}) &&
                (row_grown > {1'b0, area_top_reg[i]}) &&
                (col_ext < ({1'b0, area_right_reg[i]} + margin_ext)) &&
                (row_ext < ({1'b0, area_bottom_reg[i]} + margin_ext)))
            begin
                hit = 1'b1;
            end
        end
    end

    assign depth_ok = (depth >= cfg.depth_min) && (depth <= cfg.depth_max);
    assign push     = accept && (in_mode == MODE_PIXEL) && !hit && depth_ok;

    assign push_data.col   = col;
    assign push_data.row   = row;
    assign push_data.depth = depth;
    assign push_data.blue  = in_data[47:40];
    assign push_data.green = in_data[55:48];
    assign push_data.red   = in_data[63:56];

    always_comb
    begin
        area_count_next = area_count_reg;
        if (accept && (in_mode == MODE_COUNT))
        begin
            area_count_next = (slot > SLOT_W'(MAX_AREAS)) ? COUNT_W'(MAX_AREAS)
                                                           : COUNT_W'(slot);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_count_reg <= '0;
        end
        else
        begin
            area_count_reg <= area_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (in_mode == MODE_RECT) && (slot < SLOT_W'(MAX_AREAS)))
        begin
            area_left_reg[slot[AREA_IDX_W-1:0]]   <= rect_left;
            area_top_reg[slot[AREA_IDX_W-1:0]]    <= rect_top;
            area_right_reg[slot[AREA_IDX_W-1:0]]  <= rect_right;
            area_bottom_reg[slot[AREA_IDX_W-1:0]] <= rect_bottom;
        end
    end

endmodule

@@ design/mdbp_queue.sv @@
module mdbp_queue
    import mdbp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  pixel_t push_data,
    output logic   full,
    input  logic   pop,
    output pixel_t pop_data,
    output logic   empty
);

    pixel_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue pop while empty");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> !empty)
        else $error("pushed transaction not held in queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

@@ design/mdbp_back.sv @@
module mdbp_back
    import mdbp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  empty,
    input  pixel_t                pop_data,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data
);

    localparam int MAG_W  = POS_W;
    localparam int P1_W   = MAG_W + 16;
    localparam int HALF_W = 18;
    localparam int PP_W   = HALF_W + 24;
    localparam int PROD_W = 61;
    localparam int Q_W    = PROD_W - 32;

    function automatic logic [22:0] saturate(input logic neg, input logic [Q_W-1:0] q);
        logic [22:0] res;
        if (neg)
        begin
            res = (q > Q_W'(4194304)) ? 23'h400000 : (23'd0 - q[22:0]);
        end
        else
        begin
            res = (q > Q_W'(4194303)) ? 23'h3FFFFF : q[22:0];
        end
        return res;
    endfunction

    logic             en;
    logic             v1_reg, v2_reg, v3_reg, v4_reg;

    logic [MAG_W-1:0] magx_reg, magy_reg;
    logic             negx1_reg, negy1_reg, negx2_reg, negy2_reg, negx3_reg, negy3_reg;
    logic [15:0]      d1_reg, d2_reg, d3_reg;
    logic [23:0]      c1_reg, c2_reg, c3_reg;
    logic [P1_W-1:0]  p1x_reg, p1y_reg;
    logic [PP_W-1:0]  lox_reg, hix_reg, loy_reg, hiy_reg;

    logic [22:0]      x_reg, y_reg;
    logic [15:0]      z_reg;
    logic [23:0]      color_reg;

    logic [POS_W-1:0]  posx, posy;
    logic              negx, negy;
    logic [MAG_W-1:0]  magx, magy;
    logic [PROD_W-1:0] sumx, sumy;

    assign en  = !v4_reg || out_ready;
    assign pop = en && !empty;

    assign posx = {pop_data.col, 8'd0};
    assign posy = {pop_data.row, 8'd0};
    assign negx = posx < cfg.center_x;
    assign negy = posy < cfg.center_y;
    assign magx = negx ? (cfg.center_x - posx) : (posx - cfg.center_x);
    assign magy = negy ? (cfg.center_y - posy) : (posy - cfg.center_y);

    // rounding constant 2^31 folded into the partial-product sum
    assign sumx = {{(PROD_W - PP_W - HALF_W){1'b0}}, hix_reg, {HALF_W{1'b0}}}
                + {{(PROD_W - PP_W){1'b0}}, lox_reg}
                + (PROD_W'(1) << 31);
    assign sumy = {{(PROD_W - PP_W - HALF_W){1'b0}}, hiy_reg, {HALF_W{1'b0}}}
                + {{(PROD_W - PP_W){1'b0}}, loy_reg}
                + (PROD_W'(1) << 31);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= !empty;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            magx_reg  <= magx;
            magy_reg  <= magy;
            negx1_reg <= negx;
            negy1_reg <= negy;
            d1_reg    <= pop_data.depth;
            c1_reg    <= {pop_data.red, pop_data.green, pop_data.blue};

            p1x_reg   <= P1_W'(magx_reg) * P1_W'(d1_reg);
            p1y_reg   <= P1_W'(magy_reg) * P1_W'(d1_reg);
            negx2_reg <= negx1_reg;
            negy2_reg <= negy1_reg;
            d2_reg    <= d1_reg;
            c2_reg    <= c1_reg;

            lox_reg   <= PP_W'(p1x_reg[HALF_W-1:0]) * PP_W'(cfg.inv_focal_x);
            hix_reg   <= PP_W'(p1x_reg[P1_W-1:HALF_W]) * PP_W'(cfg.inv_focal_x);
            loy_reg   <= PP_W'(p1y_reg[HALF_W-1:0]) * PP_W'(cfg.inv_focal_y);
            hiy_reg   <= PP_W'(p1y_reg[P1_W-1:HALF_W]) * PP_W'(cfg.inv_focal_y);
            negx3_reg <= negx2_reg;
            negy3_reg <= negy2_reg;
            d3_reg    <= d2_reg;
            c3_reg    <= c2_reg;

            x_reg     <= saturate(negx3_reg, sumx[PROD_W-1:32]);
            y_reg     <= saturate(negy3_reg, sumy[PROD_W-1:32]);
            z_reg     <= d3_reg;
            color_reg <= c3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = {2'b00, color_reg, z_reg, y_reg, x_reg};

endmodule

@@ design/masked_depth_backprojection_unit.sv @@
// Pinhole back-projection of a depth pixel stream: each pixel transaction (tuser 0) that
// lies outside every active mask rectangle (grown by mask_margin on each side) and whose
// depth is within [depth_min, depth_max] yields one point with its colour, x and y in
// signed Q13.10 and z in Q6.10 metres; dropped pixels and rectangle/count load
// transactions (tuser 1, 2) yield nothing, and tuser 3 is ignored. One transaction is
// accepted every clock while the queue is not full; a point leaves through the four-stage
// multiply pipeline behind a four-entry queue. Mask checks against all active rectangle
// slots run in the accept cycle, so a load affects the very next pixel. Configuration is
// to be written by the user while the block is idle; the block does not enforce it.
module masked_depth_backprojection_unit
    import mdbp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // col, row, depth, blue, green, red, slot, rect_left, rect_top, rect_right,
    // rect_bottom, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // mode
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // x_pos, y_pos, z_pos, out_blue, out_green, out_red, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_wr_en,
    input  logic [2:0]            cfg_wr_index,
    input  logic [23:0]           cfg_wr_data
);

    cfg_t   cfg_reg;
    pixel_t push_data;
    pixel_t pop_data;
    logic   push;
    logic   pop;
    logic   full;
    logic   empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x    <= 20'd81920;
            cfg_reg.center_y    <= 20'd61440;
            cfg_reg.inv_focal_x <= 24'd31957;
            cfg_reg.inv_focal_y <= 24'd31957;
            cfg_reg.depth_min   <= 16'd102;
            cfg_reg.depth_max   <= 16'd10240;
            cfg_reg.mask_margin <= 8'd50;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_wr_index)
                CFG_CENTER_X:    cfg_reg.center_x    <= cfg_wr_data[19:0];
                CFG_CENTER_Y:    cfg_reg.center_y    <= cfg_wr_data[19:0];
                CFG_INV_FOCAL_X: cfg_reg.inv_focal_x <= cfg_wr_data;
                CFG_INV_FOCAL_Y: cfg_reg.inv_focal_y <= cfg_wr_data;
                CFG_DEPTH_MIN:   cfg_reg.depth_min   <= cfg_wr_data[15:0];
                CFG_DEPTH_MAX:   cfg_reg.depth_max   <= cfg_wr_data[15:0];
                CFG_MASK_MARGIN: cfg_reg.mask_margin <= cfg_wr_data[7:0];
                default:         ;
            endcase
        end
    end

    mdbp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .in_mode   (s_axis_tuser),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    mdbp_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    mdbp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .empty     (empty),
        .pop_data  (pop_data),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

@@ bench/tb_masked_depth_backprojection_unit.sv @@
`timescale 1ns / 100ps

module tb_masked_depth_backprojection_unit;
    import mdbp_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 265;
    localparam int COORD_TOP      = (1 << COORD_BITS) - 1;

    localparam logic [1:0] MODE_SPARE = 2'd3;

    // s_axis_tdata layout, lowest bits last
    typedef struct packed {
        logic [2:0]            pad;
        logic [COORD_BITS-1:0] rect_bottom;
        logic [COORD_BITS-1:0] rect_right;
        logic [COORD_BITS-1:0] rect_top;
        logic [COORD_BITS-1:0] rect_left;
        logic [SLOT_W-1:0]     slot;
        logic [7:0]            red;
        logic [7:0]            green;
        logic [7:0]            blue;
        logic [15:0]           depth;
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
    } in_word_t;

    // m_axis_tdata layout, lowest bits last
    typedef struct packed {
        logic [1:0]  pad;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] z_pos;
        logic [22:0] y_pos;
        logic [22:0] x_pos;
    } point_t;

    class cloud_checker;
        cfg_t                  cfg;
        logic [COORD_BITS-1:0] area_left   [MAX_AREAS];
        logic [COORD_BITS-1:0] area_top    [MAX_AREAS];
        logic [COORD_BITS-1:0] area_right  [MAX_AREAS];
        logic [COORD_BITS-1:0] area_bottom [MAX_AREAS];
        logic [SLOT_W-1:0]     area_count;
        point_t                points_due[$];
        int                    mismatches;
        int                    pixels;
        int                    loads;
        int                    projected;
        int                    checked;

        function new();
            cfg.center_x    = 20'd81920;
            cfg.center_y    = 20'd61440;
            cfg.inv_focal_x = 24'd31957;
            cfg.inv_focal_y = 24'd31957;
            cfg.depth_min   = 16'd102;
            cfg.depth_max   = 16'd10240;
            cfg.mask_margin = 8'd50;
            area_count      = '0;
            mismatches      = 0;
            pixels          = 0;
            loads           = 0;
            projected       = 0;
            checked         = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [23:0] v);
            case (idx)
                CFG_CENTER_X:    cfg.center_x    = v[19:0];
                CFG_CENTER_Y:    cfg.center_y    = v[19:0];
                CFG_INV_FOCAL_X: cfg.inv_focal_x = v;
                CFG_INV_FOCAL_Y: cfg.inv_focal_y = v;
                CFG_DEPTH_MIN:   cfg.depth_min   = v[15:0];
                CFG_DEPTH_MAX:   cfg.depth_max   = v[15:0];
                CFG_MASK_MARGIN: cfg.mask_margin = v[7:0];
                default: ;
            endcase
        endfunction

        // (pix*256 - center) * depth * recip, rounded Q.42 -> Q.10, sign applied, saturated
        function logic [22:0] backproject(logic [COORD_BITS-1:0] pix, logic [19:0] center,
                                          logic [15:0] depth, logic [23:0] recip);
            longint unsigned pos;
            longint unsigned mag;
            longint unsigned prod;
            longint unsigned q;
            logic            neg;
            pos  = 64'({pix, 8'h00});
            neg  = pos < 64'(center);
            mag  = neg ? 64'(center) - pos : pos - 64'(center);
            prod = mag * 64'(depth) * 64'(recip);
            q    = (prod + 64'h8000_0000) >> 32;
            if (neg)
                return (q > 64'd4194304) ? 23'h400000 : 23'(64'd0 - q);
            return (q > 64'd4194303) ? 23'h3FFFFF : q[22:0];
        endfunction

        // strictly inside any active rectangle grown by the margin
        function bit hidden(int c, int r);
            int m;
            int n;
            m = int'(cfg.mask_margin);
            n = (int'(area_count) > MAX_AREAS) ? MAX_AREAS : int'(area_count);
            for (int i = 0; i < n; i++)
                if (c > int'(area_left[i]) - m && r > int'(area_top[i]) - m &&
                    c < int'(area_right[i]) + m && r < int'(area_bottom[i]) + m)
                    return 1'b1;
            return 1'b0;
        endfunction

        function void take_pixel(logic [1:0] mode, in_word_t w);
            point_t p;
            case (mode)
                MODE_RECT:
                begin
                    loads++;
                    if (w.slot < MAX_AREAS)
                    begin
                        area_left[w.slot]   = w.rect_left;
                        area_top[w.slot]    = w.rect_top;
                        area_right[w.slot]  = w.rect_right;
                        area_bottom[w.slot] = w.rect_bottom;
                    end
                end
                MODE_COUNT:
                begin
                    loads++;
                    area_count = (w.slot > MAX_AREAS) ? SLOT_W'(MAX_AREAS) : w.slot;
                end
                MODE_PIXEL:
                begin
                    pixels++;
                    if (!hidden(int'(w.col), int'(w.row)) &&
                        w.depth >= cfg.depth_min && w.depth <= cfg.depth_max)
                    begin
                        p       = '0;
                        p.x_pos = backproject(w.col, cfg.center_x, w.depth, cfg.inv_focal_x);
                        p.y_pos = backproject(w.row, cfg.center_y, w.depth, cfg.inv_focal_y);
                        p.z_pos = w.depth;
                        p.blue  = w.blue;
                        p.green = w.green;
                        p.red   = w.red;
                        points_due.insert(points_due.size(), p);
                        projected++;
                    end
                end
                default: ;
            endcase
        endfunction

        task flag(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task match_point(point_t got);
            point_t want;
            if (points_due.size() == 0)
            begin
                flag($sformatf("point with none pending, tdata %h", got));
                return;
            end
            want = points_due[0];
            points_due.delete(0);
            checked++;
            if (got.x_pos !== want.x_pos)
                flag($sformatf("point %0d x_pos %h, want %h", checked, got.x_pos, want.x_pos));
            if (got.y_pos !== want.y_pos)
                flag($sformatf("point %0d y_pos %h, want %h", checked, got.y_pos, want.y_pos));
            if (got.z_pos !== want.z_pos)
                flag($sformatf("point %0d z_pos %h, want %h", checked, got.z_pos, want.z_pos));
            if (got.blue !== want.blue)
                flag($sformatf("point %0d blue %h, want %h", checked, got.blue, want.blue));
            if (got.green !== want.green)
                flag($sformatf("point %0d green %h, want %h", checked, got.green, want.green));
            if (got.red !== want.red)
                flag($sformatf("point %0d red %h, want %h", checked, got.red, want.red));
        endtask
    endclass

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [1:0]            s_axis_tuser  = MODE_PIXEL;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_wr_en     = 1'b0;
    logic [2:0]            cfg_wr_index  = CFG_CENTER_X;
    logic [23:0]           cfg_wr_data   = '0;

    cloud_checker sb;
    bit           gaps_on   = 1'b0;
    bit           stalls_on = 1'b0;
    int           stall_left = 0;
    int           quiet_cycles = 0;
    bit           written[MAX_AREAS];
    int           slots_ready = 0;

    masked_depth_backprojection_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // output side backpressure in bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (stalls_on && $urandom_range(0, 11) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= int'($urandom_range(0, 17));
        end
        else
            m_axis_tready <= 1'b1;
    end

    // transaction monitor: inputs feed the predictor, outputs are checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.take_pixel(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.match_point(m_axis_tdata);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_wr_en || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d cycles without a transaction", quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic int clip(int v, int top);
        if (v < 0)
            return 0;
        if (v > top)
            return top;
        return v;
    endfunction

    function automatic cfg_t make_cfg(logic [19:0] cx, logic [19:0] cy, logic [23:0] ix,
                                      logic [23:0] iy, logic [15:0] dmin, logic [15:0] dmax,
                                      logic [7:0] margin);
        cfg_t c;
        c.center_x    = cx;
        c.center_y    = cy;
        c.inv_focal_x = ix;
        c.inv_focal_y = iy;
        c.depth_min   = dmin;
        c.depth_max   = dmax;
        c.mask_margin = margin;
        return c;
    endfunction

    function automatic in_word_t pixel_word(int c, int r, int d, int b, int g, int rd);
        in_word_t w;
        w       = '0;
        w.col   = COORD_BITS'(c);
        w.row   = COORD_BITS'(r);
        w.depth = 16'(d);
        w.blue  = 8'(b);
        w.green = 8'(g);
        w.red   = 8'(rd);
        return w;
    endfunction

    function automatic in_word_t rect_word(int s, int l, int t, int rt, int bt);
        in_word_t w;
        w             = '0;
        w.slot        = SLOT_W'(s);
        w.rect_left   = COORD_BITS'(l);
        w.rect_top    = COORD_BITS'(t);
        w.rect_right  = COORD_BITS'(rt);
        w.rect_bottom = COORD_BITS'(bt);
        return w;
    endfunction

    function automatic in_word_t random_rect(int s);
        int l;
        int t;
        l = int'($urandom_range(0, COORD_TOP));
        t = int'($urandom_range(0, COORD_TOP));
        if ($urandom_range(0, 9) == 0)
            return rect_word(s, l, t, int'($urandom_range(0, COORD_TOP)),
                             int'($urandom_range(0, COORD_TOP)));
        return rect_word(s, l, t, clip(l + int'($urandom_range(0, 400)), COORD_TOP),
                         clip(t + int'($urandom_range(0, 400)), COORD_TOP));
    endfunction

    function automatic void mark_written(int s);
        written[s] = 1'b1;
        while (slots_ready < MAX_AREAS && written[slots_ready])
            slots_ready++;
    endfunction

    task automatic send(logic [1:0] mode, in_word_t w);
        if (gaps_on && $urandom_range(0, 9) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= mode;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic random_item(output logic [1:0] mode, output in_word_t w);
        logic [127:0] raw;
        int           pick;
        int           n;
        int           i;
        int           m;
        int           lo;
        int           hi;
        int           d;
        raw    = {$urandom, $urandom, $urandom, $urandom};
        w      = raw[IN_DATA_W-1:0];
        w.pad  = '0;
        pick   = int'($urandom_range(0, 99));
        if (pick < 78)
        begin
            mode = MODE_PIXEL;
            n    = (int'(sb.area_count) > MAX_AREAS) ? MAX_AREAS : int'(sb.area_count);
            m    = int'(sb.cfg.mask_margin);
            if (n > 0 && $urandom_range(0, 9) < 4)
            begin
                // land on or next to a grown rectangle border
                i = int'($urandom_range(0, n - 1));
                if ($urandom_range(0, 1))
                begin
                    lo    = $urandom_range(0, 1) ? int'(sb.area_left[i]) - m
                                                 : int'(sb.area_right[i]) + m;
                    w.col = COORD_BITS'(clip(lo + int'($urandom_range(0, 4)) - 2, COORD_TOP));
                    lo    = clip(int'(sb.area_top[i]) - m, COORD_TOP);
                    hi    = clip(int'(sb.area_bottom[i]) + m, COORD_TOP);
                    w.row = COORD_BITS'((lo <= hi) ? $urandom_range(lo, hi)
                                                   : $urandom_range(0, COORD_TOP));
                end
                else
                begin
                    lo    = $urandom_range(0, 1) ? int'(sb.area_top[i]) - m
                                                 : int'(sb.area_bottom[i]) + m;
                    w.row = COORD_BITS'(clip(lo + int'($urandom_range(0, 4)) - 2, COORD_TOP));
                    lo    = clip(int'(sb.area_left[i]) - m, COORD_TOP);
                    hi    = clip(int'(sb.area_right[i]) + m, COORD_TOP);
                    w.col = COORD_BITS'((lo <= hi) ? $urandom_range(lo, hi)
                                                   : $urandom_range(0, COORD_TOP));
                end
            end
            lo = int'(sb.cfg.depth_min);
            hi = int'(sb.cfg.depth_max);
            case ($urandom_range(0, 9))
                0:       d = lo - 1 + int'($urandom_range(0, 2));
                1:       d = hi - 1 + int'($urandom_range(0, 2));
                2, 3:    d = int'($urandom_range(0, 65535));
                default: d = (lo <= hi) ? int'($urandom_range(lo, hi))
                                        : int'($urandom_range(0, 65535));
            endcase
            w.depth = 16'(clip(d, 65535));
        end
        else if (pick < 86)
        begin
            mode = MODE_RECT;
            w    = random_rect(int'($urandom_range(0, MAX_AREAS - 1)));
            mark_written(int'(w.slot));
        end
        else if (pick < 92)
        begin
            mode = MODE_COUNT;
            if (slots_ready < MAX_AREAS)
                w.slot = SLOT_W'($urandom_range(0, slots_ready));
            else if ($urandom_range(0, 9) < 3)
                w.slot = SLOT_W'($urandom_range(0, 31));
            else
                w.slot = SLOT_W'($urandom_range(0, 4));
        end
        else if (pick < 96)
            mode = MODE_SPARE;
        else
        begin
            mode   = MODE_RECT;
            w.slot = SLOT_W'($urandom_range(MAX_AREAS, 31));
        end
    endtask

    task automatic pump(int items);
        logic [1:0] mode;
        in_word_t   w;
        repeat (items)
        begin
            random_item(mode, w);
            send(mode, w);
        end
    endtask

    // stop the input side and wait until every expected point has drained
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.points_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_cfg(cfg_t c);
        logic [2:0]  idx  [7];
        logic [23:0] vals [7];
        idx  = '{CFG_CENTER_X, CFG_CENTER_Y, CFG_INV_FOCAL_X, CFG_INV_FOCAL_Y,
                 CFG_DEPTH_MIN, CFG_DEPTH_MAX, CFG_MASK_MARGIN};
        vals = '{24'(c.center_x), 24'(c.center_y), c.inv_focal_x, c.inv_focal_y,
                 24'(c.depth_min), 24'(c.depth_max), 24'(c.mask_margin)};
        for (int k = 0; k < 7; k++)
        begin
            cfg_wr_en    <= 1'b1;
            cfg_wr_index <= idx[k];
            cfg_wr_data  <= vals[k];
            @(posedge clk);
            sb.set_reg(idx[k], vals[k]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(cfg_t c, bit gaps, bit stalls);
        settle();
        load_cfg(c);
        gaps_on   = gaps;
        stalls_on = stalls;
        pump(PHASE_ITEMS);
    endtask

    initial
    begin
        int lo;
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset configuration
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        send(MODE_PIXEL, pixel_word(0, 0, 102, 0, 0, 0));
        send(MODE_PIXEL, pixel_word(COORD_TOP, COORD_TOP, 10240, 255, 255, 255));
        send(MODE_PIXEL, pixel_word(320, 240, 101, 1, 2, 3));
        send(MODE_PIXEL, pixel_word(320, 240, 10241, 1, 2, 3));
        send(MODE_PIXEL, pixel_word(320, 240, 0, 1, 2, 3));
        send(MODE_PIXEL, pixel_word(640, 480, 65535, 1, 2, 3));
        send(MODE_PIXEL, pixel_word(320, 240, 1000, 10, 20, 30));
        send(MODE_SPARE, '1);
        send(MODE_RECT, rect_word(0, 100, 100, 200, 200));
        mark_written(0);
        send(MODE_COUNT, rect_word(1, 0, 0, 0, 0));
        // margin borders are exclusive
        send(MODE_PIXEL, pixel_word(50, 150, 2000, 4, 5, 6));
        send(MODE_PIXEL, pixel_word(51, 150, 2000, 4, 5, 6));
        send(MODE_PIXEL, pixel_word(250, 150, 2000, 4, 5, 6));
        send(MODE_PIXEL, pixel_word(249, 150, 2000, 4, 5, 6));
        send(MODE_PIXEL, pixel_word(150, 50, 2000, 4, 5, 6));
        send(MODE_PIXEL, pixel_word(150, 250, 2000, 4, 5, 6));
        // writes past the last slot are dropped
        send(MODE_RECT, rect_word(MAX_AREAS, 0, 0, COORD_TOP, COORD_TOP));
        send(MODE_RECT, '1);
        send(MODE_PIXEL, pixel_word(3000, 3000, 3000, 7, 8, 9));
        send(MODE_RECT, rect_word(1, COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP));
        mark_written(1);
        send(MODE_COUNT, rect_word(2, 0, 0, 0, 0));
        send(MODE_PIXEL, pixel_word(COORD_TOP, COORD_TOP, 1000, 7, 8, 9));
        send(MODE_PIXEL, pixel_word(3000, 3000, 1000, 7, 8, 9));
        send(MODE_COUNT, rect_word(0, 0, 0, 0, 0));
        send(MODE_PIXEL, pixel_word(150, 150, 2000, 7, 8, 9));

        // fill every slot, then random traffic at reset settings
        for (int s = 0; s < MAX_AREAS; s++)
        begin
            send(MODE_RECT, random_rect(s));
            mark_written(s);
        end
        pump(PHASE_ITEMS);

        run_phase(make_cfg(20'd0, 20'd0, 24'hFFFFFF, 24'hFFFFFF, 16'd0, 16'hFFFF, 8'd0),
                  1'b1, 1'b0);
        run_phase(make_cfg(20'hFFFFF, 20'hFFFFF, 24'd0, 24'($urandom_range(0, 24'hFFFFFF)),
                           16'd500, 16'd3000, 8'd255), 1'b0, 1'b1);
        lo = int'($urandom_range(0, 30000));
        run_phase(make_cfg(20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF)),
                           24'($urandom_range(0, 1 << 17)), 24'($urandom_range(0, 1 << 17)),
                           16'(lo), 16'($urandom_range(lo, 65535)),
                           8'($urandom_range(0, 255))),
                  1'b1, 1'b1);
        // empty depth window
        run_phase(make_cfg(20'd81920, 20'd61440, 24'd31957, 24'd31957, 16'd5000, 16'd4000,
                           8'd1), 1'b1, 1'b1);
        // closing stretch without idling
        run_phase(make_cfg(20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF)),
                           24'($urandom_range(0, 24'hFFFFFF)),
                           24'($urandom_range(0, 24'hFFFFFF)),
                           16'd0, 16'hFFFF, 8'($urandom_range(0, 255))), 1'b0, 1'b0);
        settle();

        $display("covered %0d pixels (%0d projected, %0d points checked), %0d slot/count loads",
                 sb.pixels, sb.projected, sb.checked, sb.loads);
        $display("over reset and five programmed settings incl. extreme centers, focal, depths");
        if (sb.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
